[design/cgd_pkg.sv]
`timescale 1ns / 1ps
// Shared types, codes and constants of the cell grid dig engine.
package cgd_pkg;

	localparam int MAX_WIDTH_DEF   = 256;
	localparam int MAX_HEIGHT_DEF  = 256;
	localparam int MAX_RADIUS      = 255;
	localparam int QUEUE_DEPTH_DEF = 2;

	localparam int CMD_W   = 3;
	localparam int POS_W   = 16;
	localparam int SIZE_W  = 16;
	localparam int RAD_W   = 8;
	localparam int CODE_W  = 8;
	localparam int CELL_W  = 16;
	localparam int COUNT_W = 17;
	localparam int GRID_CW = 9;   // on-grid coordinates and grid size registers
	localparam int COORD_W = 19;  // signed working width of the classifier
	localparam int OFS_W   = 9;   // signed offset from a circle center
	localparam int SQ_W    = 16;  // squared offsets and squared radius

	localparam logic [CMD_W-1:0] CMD_READ       = 3'd0;
	localparam logic [CMD_W-1:0] CMD_WRITE_CELL = 3'd1;
	localparam logic [CMD_W-1:0] CMD_WRITE_MAT  = 3'd2;
	localparam logic [CMD_W-1:0] CMD_WRITE_BG   = 3'd3;
	localparam logic [CMD_W-1:0] CMD_DIG_CIRCLE = 3'd4;
	localparam logic [CMD_W-1:0] CMD_DIG_RECT   = 3'd5;

	localparam logic REG_GRID_WIDTH  = 1'b0;
	localparam logic REG_GRID_HEIGHT = 1'b1;
	localparam logic [GRID_CW-1:0] GRID_SIZE_RESET = 9'd256;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_READ,
		OP_WR_CELL,
		OP_WR_MAT,
		OP_WR_BG,
		OP_DIG
	} op_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_START,
		ST_RD_WAIT,
		ST_RMW,
		ST_SCAN,
		ST_SCAN_END,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [CMD_W-1:0]         command;
		logic signed [POS_W-1:0]  x_pos;
		logic signed [POS_W-1:0]  y_pos;
		logic [RAD_W-1:0]         radius;
		logic [SIZE_W-1:0]        rect_width;
		logic [SIZE_W-1:0]        rect_height;
		logic [CODE_W-1:0]        material_value;
		logic [CODE_W-1:0]        background_value;
	} request_t;

	typedef struct packed {
		logic [CODE_W-1:0]  material_out;
		logic [CODE_W-1:0]  background_out;
		logic [COUNT_W-1:0] changed_count;
		logic               in_bounds;
	} result_t;

	// Classified command handed from the front end to the executor.
	typedef struct packed {
		op_t                     op;
		logic                    in_bounds;
		logic                    circle;
		logic [GRID_CW-1:0]      x0;
		logic [GRID_CW-1:0]      y0;
		logic [GRID_CW-1:0]      x1;
		logic [GRID_CW-1:0]      y1;
		logic signed [OFS_W-1:0] dx0;
		logic signed [OFS_W-1:0] dy0;
		logic [RAD_W-1:0]        radius;
		logic [SQ_W-1:0]         dx0_sq;
		logic [SQ_W-1:0]         dy0_sq;
		logic [SQ_W-1:0]         r_sq;
		logic [CODE_W-1:0]       material;
		logic [CODE_W-1:0]       background;
	} desc_t;

endpackage

[design/cgd_queue.sv]
`timescale 1ns / 1ps
// Small FIFO of classified commands between front end and executor.
module cgd_queue #(
	parameter int DEPTH = cgd_pkg::QUEUE_DEPTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  cgd_pkg::desc_t push_desc,
	input  logic           pop,
	output cgd_pkg::desc_t head_desc,
	output logic           full,
	output logic           empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	cgd_pkg::desc_t entry_q [DEPTH];
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [CW-1:0]  fill_q;
	logic           do_push;
	logic           do_pop;

	assign full      = (fill_q == CW'(DEPTH));
	assign empty     = (fill_q == '0);
	assign do_push   = push && !full;
	assign do_pop    = pop && !empty;
	assign head_desc = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + CW'(1);
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_desc;
		end
	end

endmodule

[design/cgd_front.sv]
`timescale 1ns / 1ps
// Front end: takes commands, clips them to the grid and queues a descriptor.
module cgd_front #(
	parameter int MAX_WIDTH  = cgd_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = cgd_pkg::MAX_HEIGHT_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  cgd_pkg::request_t             request,
	input  logic [cgd_pkg::GRID_CW-1:0]   grid_width,
	input  logic [cgd_pkg::GRID_CW-1:0]   grid_height,
	input  logic                          clearing,
	output logic                          push,
	output cgd_pkg::desc_t                push_desc,
	input  logic                          queue_full
);

	localparam int CW = cgd_pkg::COORD_W;
	localparam logic signed [CW-1:0] ONE = CW'(1);

	logic              valid_s1;
	logic              valid_s2;
	cgd_pkg::request_t req_s1;
	cgd_pkg::desc_t    desc_s2;
	cgd_pkg::desc_t    desc_d;
	logic              adv1;
	logic              accept;

	logic signed [CW-1:0] cx, cy, rr, rw, rh, uw, uh;
	logic signed [CW-1:0] xlo, xhi, ylo, yhi, x0c, x1c, y0c, y1c, dx0, dy0;
	logic [cgd_pkg::RAD_W-1:0] r;
	logic inb;
	logic box_empty;

	logic signed [2*cgd_pkg::OFS_W-1:0] dx_sq;
	logic signed [2*cgd_pkg::OFS_W-1:0] dy_sq;
	logic [2*cgd_pkg::RAD_W-1:0]        r_sq;

	assign push   = valid_s2 && !queue_full;
	assign adv1   = valid_s1 && (!valid_s2 || push);
	assign busy   = clearing || (valid_s1 && !(!valid_s2 || push));
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (adv1) begin
				valid_s1 <= 1'b0;
			end
			if (adv1) begin
				valid_s2 <= 1'b1;
			end else if (push) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1 <= request;
		end
		if (adv1) begin
			desc_s2 <= desc_d;
		end
	end

	// Classification and clipping
	always_comb begin
		r  = (int'(req_s1.radius) > cgd_pkg::MAX_RADIUS) ?
			cgd_pkg::RAD_W'(cgd_pkg::MAX_RADIUS) : req_s1.radius;
		cx = {{(CW - cgd_pkg::POS_W){req_s1.x_pos[cgd_pkg::POS_W-1]}}, req_s1.x_pos};
		cy = {{(CW - cgd_pkg::POS_W){req_s1.y_pos[cgd_pkg::POS_W-1]}}, req_s1.y_pos};
		rr = CW'(r);
		rw = CW'(req_s1.rect_width);
		rh = CW'(req_s1.rect_height);
		uw = (int'(grid_width) > MAX_WIDTH) ? CW'(MAX_WIDTH) : CW'(grid_width);
		uh = (int'(grid_height) > MAX_HEIGHT) ? CW'(MAX_HEIGHT) : CW'(grid_height);

		inb = (cx >= 0) && (cx < uw) && (cy >= 0) && (cy < uh);

		if (req_s1.command == cgd_pkg::CMD_DIG_CIRCLE) begin
			xlo = cx - rr;
			xhi = cx + rr;
			ylo = cy - rr;
			yhi = cy + rr;
		end else begin
			xlo = cx;
			xhi = cx + rw - ONE;
			ylo = cy;
			yhi = cy + rh - ONE;
		end
		x0c = (xlo < 0) ? '0 : xlo;
		y0c = (ylo < 0) ? '0 : ylo;
		x1c = (xhi > uw - ONE) ? uw - ONE : xhi;
		y1c = (yhi > uh - ONE) ? uh - ONE : yhi;
		box_empty = (x0c > x1c) || (y0c > y1c);

		// offset of the first visited column and row from the center
		dx0 = (-rr > -cx) ? -rr : -cx;
		dy0 = (-rr > -cy) ? -rr : -cy;

		desc_d            = '0;
		desc_d.op         = cgd_pkg::OP_NONE;
		desc_d.in_bounds  = inb;
		desc_d.circle     = (req_s1.command == cgd_pkg::CMD_DIG_CIRCLE);
		desc_d.radius     = r;
		desc_d.material   = req_s1.material_value;
		desc_d.background = req_s1.background_value;
		desc_d.dx0        = cgd_pkg::OFS_W'(dx0);
		desc_d.dy0        = cgd_pkg::OFS_W'(dy0);
		desc_d.x0         = cgd_pkg::GRID_CW'(cx);
		desc_d.y0         = cgd_pkg::GRID_CW'(cy);
		desc_d.x1         = cgd_pkg::GRID_CW'(x1c);
		desc_d.y1         = cgd_pkg::GRID_CW'(y1c);

		case (req_s1.command)
			cgd_pkg::CMD_READ: begin
				if (inb) desc_d.op = cgd_pkg::OP_READ;
			end
			cgd_pkg::CMD_WRITE_CELL: begin
				if (inb) desc_d.op = cgd_pkg::OP_WR_CELL;
			end
			cgd_pkg::CMD_WRITE_MAT: begin
				if (inb) desc_d.op = cgd_pkg::OP_WR_MAT;
			end
			cgd_pkg::CMD_WRITE_BG: begin
				if (inb) desc_d.op = cgd_pkg::OP_WR_BG;
			end
			cgd_pkg::CMD_DIG_CIRCLE, cgd_pkg::CMD_DIG_RECT: begin
				desc_d.x0 = cgd_pkg::GRID_CW'(x0c);
				desc_d.y0 = cgd_pkg::GRID_CW'(y0c);
				if (!box_empty) desc_d.op = cgd_pkg::OP_DIG;
			end
			default: begin
				desc_d.op = cgd_pkg::OP_NONE;
			end
		endcase
	end

	// Squares for the circle test, one multiplier per term
	always_comb begin
		dx_sq                = desc_s2.dx0 * desc_s2.dx0;
		dy_sq                = desc_s2.dy0 * desc_s2.dy0;
		r_sq                 = desc_s2.radius * desc_s2.radius;
		push_desc            = desc_s2;
		push_desc.dx0_sq     = cgd_pkg::SQ_W'(dx_sq);
		push_desc.dy0_sq     = cgd_pkg::SQ_W'(dy_sq);
		push_desc.r_sq       = cgd_pkg::SQ_W'(r_sq);
	end

endmodule

[design/cgd_back.sv]
`timescale 1ns / 1ps
// Executor: owns the cell memory, runs single-cell accesses and dig scans.
module cgd_back #(
	parameter int MAX_WIDTH  = cgd_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = cgd_pkg::MAX_HEIGHT_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             queue_empty,
	input  cgd_pkg::desc_t   head_desc,
	output logic             pop,
	output logic             clearing,
	output logic             done,
	output cgd_pkg::result_t result
);

	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int GW    = cgd_pkg::GRID_CW;
	localparam int SW    = cgd_pkg::SQ_W;
	localparam int OW    = cgd_pkg::OFS_W;

	logic [cgd_pkg::CELL_W-1:0] mem [DEPTH];
	logic [cgd_pkg::CELL_W-1:0] rd_data_q;

	cgd_pkg::state_t state_q, state_d;
	cgd_pkg::desc_t  desc_q;

	logic [AW-1:0]  clr_addr_q;
	logic [GW-1:0]  cur_x_q, cur_y_q;
	logic signed [OW-1:0] dx_q, dy_q;
	logic [SW-1:0]  dx2_q, dy2_q;
	logic           pend_s1;
	logic [AW-1:0]  pend_addr_s1;
	logic [cgd_pkg::COUNT_W-1:0] count_q;
	logic           done_q;
	cgd_pkg::result_t result_q;

	logic           mem_we;
	logic [AW-1:0]  mem_waddr, mem_raddr;
	logic [cgd_pkg::CELL_W-1:0] mem_wdata;
	logic [AW-1:0]  cur_addr, desc_addr;
	logic           hit, row_end, last, dirty, emit;
	logic signed [SW+1:0] dx2_next, dy2_next;
	cgd_pkg::result_t res_d;

	function automatic logic [AW-1:0] cell_addr(input logic [GW-1:0] cy,
	                                            input logic [GW-1:0] cx);
		return AW'(cy) * AW'(MAX_WIDTH) + AW'(cx);
	endfunction

	assign cur_addr  = cell_addr(cur_y_q, cur_x_q);
	assign desc_addr = cell_addr(desc_q.y0, desc_q.x0);
	assign hit       = !desc_q.circle ||
		({1'b0, dx2_q} + {1'b0, dy2_q} <= {1'b0, desc_q.r_sq});
	assign row_end   = (cur_x_q == desc_q.x1);
	assign last      = row_end && (cur_y_q == desc_q.y1);
	assign dirty     = pend_s1 && (rd_data_q[cgd_pkg::CODE_W-1:0] != desc_q.material);
	// (d+1)^2 = d^2 + 2d + 1
	assign dx2_next  = $signed({2'b00, dx2_q}) +
		$signed({{(SW + 2 - OW - 1){dx_q[OW-1]}}, dx_q, 1'b1});
	assign dy2_next  = $signed({2'b00, dy2_q}) +
		$signed({{(SW + 2 - OW - 1){dy_q[OW-1]}}, dy_q, 1'b1});
	assign clearing  = (state_q == cgd_pkg::ST_CLEAR);
	assign done      = done_q;
	assign result    = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= cgd_pkg::ST_CLEAR;
			clr_addr_q <= '0;
			pend_s1    <= 1'b0;
			done_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == cgd_pkg::ST_CLEAR) begin
				clr_addr_q <= clr_addr_q + AW'(1);
			end
			pend_s1 <= (state_q == cgd_pkg::ST_SCAN) && hit;
			done_q  <= emit;
		end
	end

	always_comb begin
		state_d   = state_q;
		pop       = 1'b0;
		emit      = 1'b0;
		res_d     = '0;
		res_d.in_bounds = desc_q.in_bounds;
		mem_raddr = cur_addr;
		// write-back stage of the dig scan
		mem_we    = dirty;
		mem_waddr = pend_addr_s1;
		mem_wdata = {rd_data_q[cgd_pkg::CELL_W-1:cgd_pkg::CODE_W], desc_q.material};

		case (state_q)
			cgd_pkg::ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_addr_q;
				mem_wdata = '0;
				if (clr_addr_q == AW'(DEPTH - 1)) state_d = cgd_pkg::ST_IDLE;
			end
			cgd_pkg::ST_IDLE: begin
				if (!queue_empty) begin
					pop     = 1'b1;
					state_d = cgd_pkg::ST_START;
				end
			end
			cgd_pkg::ST_START: begin
				case (desc_q.op)
					cgd_pkg::OP_READ: begin
						mem_raddr = desc_addr;
						state_d   = cgd_pkg::ST_RD_WAIT;
					end
					cgd_pkg::OP_WR_CELL: begin
						mem_we    = 1'b1;
						mem_waddr = desc_addr;
						mem_wdata = {desc_q.background, desc_q.material};
						emit      = 1'b1;
						state_d   = cgd_pkg::ST_IDLE;
					end
					cgd_pkg::OP_WR_MAT, cgd_pkg::OP_WR_BG: begin
						mem_raddr = desc_addr;
						state_d   = cgd_pkg::ST_RMW;
					end
					cgd_pkg::OP_DIG: begin
						state_d = cgd_pkg::ST_SCAN;
					end
					default: begin
						emit    = 1'b1;
						state_d = cgd_pkg::ST_IDLE;
					end
				endcase
			end
			cgd_pkg::ST_RD_WAIT: begin
				res_d.material_out   = rd_data_q[cgd_pkg::CODE_W-1:0];
				res_d.background_out = rd_data_q[cgd_pkg::CELL_W-1:cgd_pkg::CODE_W];
				emit    = 1'b1;
				state_d = cgd_pkg::ST_IDLE;
			end
			cgd_pkg::ST_RMW: begin
				mem_we    = 1'b1;
				mem_waddr = desc_addr;
				if (desc_q.op == cgd_pkg::OP_WR_MAT) begin
					mem_wdata = {rd_data_q[cgd_pkg::CELL_W-1:cgd_pkg::CODE_W],
						desc_q.material};
				end else begin
					mem_wdata = {desc_q.background, rd_data_q[cgd_pkg::CODE_W-1:0]};
				end
				emit    = 1'b1;
				state_d = cgd_pkg::ST_IDLE;
			end
			cgd_pkg::ST_SCAN: begin
				if (last) state_d = cgd_pkg::ST_SCAN_END;
			end
			cgd_pkg::ST_SCAN_END: begin
				state_d = cgd_pkg::ST_DONE;
			end
			cgd_pkg::ST_DONE: begin
				res_d.changed_count = count_q;
				emit    = 1'b1;
				state_d = cgd_pkg::ST_IDLE;
			end
			default: begin
				state_d = cgd_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == cgd_pkg::ST_IDLE && !queue_empty) begin
			desc_q  <= head_desc;
			cur_x_q <= head_desc.x0;
			cur_y_q <= head_desc.y0;
			dx_q    <= head_desc.dx0;
			dy_q    <= head_desc.dy0;
			dx2_q   <= head_desc.dx0_sq;
			dy2_q   <= head_desc.dy0_sq;
			count_q <= '0;
		end else begin
			if (state_q == cgd_pkg::ST_SCAN && !last) begin
				if (row_end) begin
					cur_x_q <= desc_q.x0;
					cur_y_q <= cur_y_q + GW'(1);
					dx_q    <= desc_q.dx0;
					dx2_q   <= desc_q.dx0_sq;
					dy_q    <= dy_q + OW'(1);
					dy2_q   <= SW'(dy2_next);
				end else begin
					cur_x_q <= cur_x_q + GW'(1);
					dx_q    <= dx_q + OW'(1);
					dx2_q   <= SW'(dx2_next);
				end
			end
			if (dirty && count_q != '1) begin
				count_q <= count_q + cgd_pkg::COUNT_W'(1);
			end
		end
		pend_addr_s1 <= cur_addr;
		if (emit) begin
			result_q <= res_d;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rd_data_q <= mem[mem_raddr];
	end

endmodule

[design/cell_grid_dig_engine_core.sv]
`timescale 1ns / 1ps
// Top level of the cell grid dig engine: config registers, front end, queue, executor.
//
// A command transaction is taken when start is high and busy is low; each one yields
// exactly one result, shown for one cycle with done high. The receiver cannot stall,
// so results leave in command order as soon as they are ready. After reset the cell
// memory is cleared one cell per cycle, with busy held high; config writes are taken
// during that pass. A command runs through a two-stage classifier (clip to grid, square
// the start offsets) and a QUEUE_DEPTH-entry queue, so the front keeps taking commands
// while the executor works, until the queue is full. In the executor a read passes the
// start and read-wait states, a whole-cell write or an off-grid or unused command only
// the start state, a material or background write the start and read-modify-write
// states. A dig scans the clipped bounding box one cell per cycle through a pipelined
// read-modify-write on the single-port-pair memory; the box is up to (2r+1) by (2r+1)
// cells for a circle of radius r, width by height for a rectangle. Besides the executor
// a command passes the two front-end stages, the queue and the result register. The
// user must write grid width and height only while idle; the block does not enforce it.
module cell_grid_dig_engine_core #(
	parameter int MAX_WIDTH   = cgd_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT  = cgd_pkg::MAX_HEIGHT_DEF,
	parameter int QUEUE_DEPTH = cgd_pkg::QUEUE_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  cgd_pkg::request_t request,
	output logic              done,
	output cgd_pkg::result_t  result,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	logic [cgd_pkg::GRID_CW-1:0] grid_width_q;
	logic [cgd_pkg::GRID_CW-1:0] grid_height_q;
	logic           clearing;
	logic           push;
	cgd_pkg::desc_t push_desc;
	cgd_pkg::desc_t head_desc;
	logic           queue_full;
	logic           queue_empty;
	logic           pop;

	assign pready = 1'b1;

	// register file: word index from paddr[2]
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q  <= cgd_pkg::GRID_SIZE_RESET;
			grid_height_q <= cgd_pkg::GRID_SIZE_RESET;
		end else if (psel && penable && pwrite && pready) begin
			case (paddr[2])
				cgd_pkg::REG_GRID_WIDTH:  grid_width_q  <= pwdata[cgd_pkg::GRID_CW-1:0];
				cgd_pkg::REG_GRID_HEIGHT: grid_height_q <= pwdata[cgd_pkg::GRID_CW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			cgd_pkg::REG_GRID_WIDTH:  prdata = 32'(grid_width_q);
			cgd_pkg::REG_GRID_HEIGHT: prdata = 32'(grid_height_q);
			default:                  prdata = '0;
		endcase
	end

	cgd_front #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.request     (request),
		.grid_width  (grid_width_q),
		.grid_height (grid_height_q),
		.clearing    (clearing),
		.push        (push),
		.push_desc   (push_desc),
		.queue_full  (queue_full)
	);

	cgd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_desc (push_desc),
		.pop       (pop),
		.head_desc (head_desc),
		.full      (queue_full),
		.empty     (queue_empty)
	);

	cgd_back #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.queue_empty (queue_empty),
		.head_desc   (head_desc),
		.pop         (pop),
		.clearing    (clearing),
		.done        (done),
		.result      (result)
	);

endmodule

[design/cgd_checker.sv]
`timescale 1ns / 1ps
// Port-level checker of the cell grid dig engine and its bind.
module cgd_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             start,
	input logic             busy,
	input logic             done,
	input cgd_pkg::result_t result
);

	// every result passes through the idle state, so strobes never touch
	a_done_spaced: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobes in consecutive cycles");

	a_offgrid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !result.in_bounds |->
			result.material_out == '0 && result.background_out == '0)
		else $error("off-grid result carries cell data");

	a_count_or_data: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> result.changed_count == '0 ||
			(result.material_out == '0 && result.background_out == '0))
		else $error("result has both a dig count and cell data");

	a_clear_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(arst_n) |-> busy)
		else $error("command port open right after reset");

	a_no_accept_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(arst_n) |-> !(start && !busy))
		else $error("transaction taken during memory clear");

endmodule

bind cell_grid_dig_engine_core cgd_checker u_checker (.*);

[sim/cgd_result_checker.sv]
`timescale 1ns / 1ps
// Result checker for the cell grid dig engine: mirrors the cell store and scores each result.
module cgd_result_checker #(
	parameter int MAX_WIDTH  = cgd_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = cgd_pkg::MAX_HEIGHT_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              busy,
	input  cgd_pkg::request_t request,
	input  logic              done,
	input  cgd_pkg::result_t  result,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	input  logic [31:0]       prdata,
	input  logic              pready,
	output int                fail_count,
	output int                pending,
	output int                checked
);
	import cgd_pkg::*;

	localparam int COUNT_MAX = (1 << COUNT_W) - 1;
	localparam logic [2:0] ADDR_GRID_WIDTH  = {REG_GRID_WIDTH, 2'b00};
	localparam logic [2:0] ADDR_GRID_HEIGHT = {REG_GRID_HEIGHT, 2'b00};

	logic [CELL_W-1:0]  grid_cells [MAX_WIDTH*MAX_HEIGHT];
	logic [GRID_CW-1:0] grid_w_reg;
	logic [GRID_CW-1:0] grid_h_reg;
	logic [GRID_CW-1:0] reg_val;
	result_t            expected_results [$];
	result_t            exp_res;

	function automatic int cols_in_use();
		return (grid_w_reg > MAX_WIDTH) ? MAX_WIDTH : int'(grid_w_reg);
	endfunction

	function automatic int rows_in_use();
		return (grid_h_reg > MAX_HEIGHT) ? MAX_HEIGHT : int'(grid_h_reg);
	endfunction

	function automatic bit on_grid(int x, int y);
		return x >= 0 && x < cols_in_use() && y >= 0 && y < rows_in_use();
	endfunction

	// Set one on-grid cell to air; 1 when its material changed.
	function automatic int clear_to_air(int x, int y, logic [CODE_W-1:0] air);
		int idx;
		idx = y * MAX_WIDTH + x;
		if (grid_cells[idx][CODE_W-1:0] == air)
			return 0;
		grid_cells[idx][CODE_W-1:0] = air;
		return 1;
	endfunction

	// Apply one command to the mirrored store and return the result it should give.
	function automatic result_t predict_cell_command(request_t req);
		result_t           res;
		int                x, y, idx, rad, x0, x1, y0, y1, px, py, count;
		logic [CELL_W-1:0] word;
		res = '0;
		x = $signed(req.x_pos);
		y = $signed(req.y_pos);
		res.in_bounds = on_grid(x, y);
		idx = y * MAX_WIDTH + x;
		count = 0;
		case (req.command)
			CMD_READ: if (res.in_bounds) begin
				word = grid_cells[idx];
				res.material_out   = word[CODE_W-1:0];
				res.background_out = word[CELL_W-1:CODE_W];
			end
			CMD_WRITE_CELL: if (res.in_bounds) begin
				grid_cells[idx] = {req.background_value, req.material_value};
			end
			CMD_WRITE_MAT: if (res.in_bounds) begin
				grid_cells[idx][CODE_W-1:0] = req.material_value;
			end
			CMD_WRITE_BG: if (res.in_bounds) begin
				grid_cells[idx][CELL_W-1:CODE_W] = req.background_value;
			end
			CMD_DIG_CIRCLE: begin
				rad = (req.radius > MAX_RADIUS) ? MAX_RADIUS : int'(req.radius);
				x0 = (x - rad < 0) ? 0 : x - rad;
				y0 = (y - rad < 0) ? 0 : y - rad;
				x1 = (x + rad > cols_in_use() - 1) ? cols_in_use() - 1 : x + rad;
				y1 = (y + rad > rows_in_use() - 1) ? rows_in_use() - 1 : y + rad;
				for (py = y0; py <= y1; py++)
					for (px = x0; px <= x1; px++)
						if ((px - x) * (px - x) + (py - y) * (py - y) <= rad * rad) begin
							count += clear_to_air(px, py, req.material_value);
							if (count > COUNT_MAX)
								count = COUNT_MAX;
						end
			end
			CMD_DIG_RECT: begin
				x0 = (x < 0) ? 0 : x;
				y0 = (y < 0) ? 0 : y;
				x1 = x + int'(req.rect_width);
				y1 = y + int'(req.rect_height);
				if (x1 > cols_in_use())
					x1 = cols_in_use();
				if (y1 > rows_in_use())
					y1 = rows_in_use();
				for (py = y0; py < y1; py++)
					for (px = x0; px < x1; px++) begin
						count += clear_to_air(px, py, req.material_value);
						if (count > COUNT_MAX)
							count = COUNT_MAX;
					end
			end
			default: ;
		endcase
		res.changed_count = COUNT_W'(count);
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (grid_cells[i])
				grid_cells[i] = '0;
			grid_w_reg = GRID_SIZE_RESET;
			grid_h_reg = GRID_SIZE_RESET;
			expected_results.delete();
			fail_count = 0;
			pending    = 0;
			checked    = 0;
		end else begin
			// a result never belongs to the command taken on the same edge
			if (done) begin
				if (expected_results.size() == 0) begin
					$error("result with no command outstanding");
					fail_count++;
				end else begin
					exp_res = expected_results.pop_front();
					checked++;
					if (result.material_out !== exp_res.material_out) begin
						$error("material_out mismatch: expected %0d, got %0d",
							exp_res.material_out, result.material_out);
						fail_count++;
					end
					if (result.background_out !== exp_res.background_out) begin
						$error("background_out mismatch: expected %0d, got %0d",
							exp_res.background_out, result.background_out);
						fail_count++;
					end
					if (result.changed_count !== exp_res.changed_count) begin
						$error("changed_count mismatch: expected %0d, got %0d",
							exp_res.changed_count, result.changed_count);
						fail_count++;
					end
					if (result.in_bounds !== exp_res.in_bounds) begin
						$error("in_bounds mismatch: expected %0d, got %0d",
							exp_res.in_bounds, result.in_bounds);
						fail_count++;
					end
				end
			end
			if (start && !busy)
				expected_results.push_back(predict_cell_command(request));
			if (psel && penable && pready) begin
				if (pwrite) begin
					if (paddr == ADDR_GRID_WIDTH)
						grid_w_reg = pwdata[GRID_CW-1:0];
					else if (paddr == ADDR_GRID_HEIGHT)
						grid_h_reg = pwdata[GRID_CW-1:0];
				end else if (paddr == ADDR_GRID_WIDTH || paddr == ADDR_GRID_HEIGHT) begin
					reg_val = (paddr == ADDR_GRID_WIDTH) ? grid_w_reg : grid_h_reg;
					if (prdata[GRID_CW-1:0] !== reg_val) begin
						$error("prdata mismatch: expected %0d, got %0d",
							reg_val, prdata[GRID_CW-1:0]);
						fail_count++;
					end
				end
			end
			pending = expected_results.size();
		end
	end

endmodule

[sim/cell_grid_dig_engine_core_tb.sv]
`timescale 1ns / 1ps
// Testbench top for the cell grid dig engine: clock, reset, command and register stimulus, verdict.
module cell_grid_dig_engine_core_tb;
	import cgd_pkg::*;

	// Longest quiet stretch of a correct run is the clear pass or one full-grid dig;
	// the limit is several times that.
	localparam int WATCHDOG_LIMIT = 400000;
	// Every command gives a result, so once nothing is pending the block is idle;
	// a short settle still lets any stray result show up before the next step.
	localparam int SETTLE_CYCLES  = 32;
	// Grids up to this many cells take any dig size: the scan is clipped to the grid.
	localparam int ROOMY_CELLS    = 1024;

	localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
	localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;
	localparam logic [2:0] ADDR_GRID_WIDTH  = {REG_GRID_WIDTH, 2'b00};
	localparam logic [2:0] ADDR_GRID_HEIGHT = {REG_GRID_HEIGHT, 2'b00};

	logic        clk     = 1'b0;
	logic        arst_n  = 1'b0;
	logic        start   = 1'b0;
	logic        busy;
	request_t    request = '0;
	logic        done;
	result_t     result;
	logic        psel    = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite  = 1'b0;
	logic [2:0]  paddr   = '0;
	logic [31:0] pwdata  = '0;
	logic [31:0] prdata;
	logic        pready;

	int   fail_count;
	int   pending;
	int   checked;
	logic cmd_taken;
	int   idle_cycles = 0;

	// grid size as the block uses it, after saturation; shapes the random commands
	int cols_used = MAX_WIDTH_DEF;
	int rows_used = MAX_HEIGHT_DEF;

	int n_reads  = 0;
	int n_writes = 0;
	int n_digs   = 0;
	int n_spare  = 0;
	int n_grids  = 1;

	cell_grid_dig_engine_core uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.request (request),
		.done    (done),
		.result  (result),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	cgd_result_checker result_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.request    (request),
		.done       (done),
		.result     (result),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.fail_count (fail_count),
		.pending    (pending),
		.checked    (checked)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Registered copy of the command handshake, read by the driver at the falling
	// edge: tells whether the rising edge just gone took the command transaction.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			cmd_taken <= 1'b0;
		else
			cmd_taken <= start && !busy;
	end

	// Watchdog: counts cycles with no transaction on either channel.
	always @(posedge clk) begin
		if ((start && !busy) || done) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("Timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
				$display("Verification failed");
				$finish;
			end
		end
	end

	// Present one command and hold it until taken. Entered and left at a falling
	// edge; start stays high on return so back-to-back commands need no gap.
	task automatic issue(request_t req);
		request <= req;
		start   <= 1'b1;
		do @(negedge clk); while (!cmd_taken);
		case (req.command)
			CMD_READ: n_reads++;
			CMD_WRITE_CELL, CMD_WRITE_MAT, CMD_WRITE_BG: n_writes++;
			CMD_DIG_CIRCLE, CMD_DIG_RECT: n_digs++;
			default: n_spare++;
		endcase
	endtask

	task automatic rest(int cycles);
		start <= 1'b0;
		repeat (cycles) @(negedge clk);
	endtask

	// Sender holds off until every outstanding result is back.
	task automatic drain();
		start <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Register write (setup + access), then a read-back of the same register.
	// Bits above the register width carry noise; the register keeps only its own.
	task automatic write_reg(logic [2:0] addr, logic [GRID_CW-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= {23'($urandom), value};
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
	endtask

	// Grid size changes only with the block idle.
	task automatic set_grid(int w, int h);
		drain();
		write_reg(ADDR_GRID_WIDTH, GRID_CW'(w));
		write_reg(ADDR_GRID_HEIGHT, GRID_CW'(h));
		cols_used = (w > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : w;
		rows_used = (h > MAX_HEIGHT_DEF) ? MAX_HEIGHT_DEF : h;
		n_grids++;
	endtask

	function automatic request_t make_cmd(logic [CMD_W-1:0] op, int x, int y, int rad,
		int w, int h, int mat, int bg);
		request_t req;
		req.command          = op;
		req.x_pos            = 16'(x);
		req.y_pos            = 16'(y);
		req.radius           = 8'(rad);
		req.rect_width       = 16'(w);
		req.rect_height      = 16'(h);
		req.material_value   = 8'(mat);
		req.background_value = 8'(bg);
		return req;
	endfunction

	// Random command: positions mostly on the grid or up to three cells off it, so
	// on- and off-grid both come up often, now and then anywhere in the 16-bit range.
	// Air codes come from a small set half the time, so digs also meet cells already
	// at air. Sizes are only unbounded where the grid itself keeps the scan short.
	function automatic request_t random_item();
		request_t req;
		int       pick;
		int       lane;
		bit       roomy;
		req   = '0;
		roomy = (cols_used * rows_used <= ROOMY_CELLS);
		pick  = $urandom_range(0, 99);
		if (pick < 22)
			req.command = CMD_READ;
		else if (pick < 36)
			req.command = CMD_WRITE_CELL;
		else if (pick < 46)
			req.command = CMD_WRITE_MAT;
		else if (pick < 56)
			req.command = CMD_WRITE_BG;
		else if (pick < 76)
			req.command = CMD_DIG_CIRCLE;
		else if (pick < 94)
			req.command = CMD_DIG_RECT;
		else
			req.command = $urandom_range(0, 1) ? CMD_SPARE_6 : CMD_SPARE_7;

		if ($urandom_range(0, 9) == 0)
			req.x_pos = 16'($urandom);
		else
			req.x_pos = 16'(int'($urandom_range(0, cols_used + 5)) - 3);
		if ($urandom_range(0, 9) == 0)
			req.y_pos = 16'($urandom);
		else
			req.y_pos = 16'(int'($urandom_range(0, rows_used + 5)) - 3);

		if (roomy) begin
			req.radius = ($urandom_range(0, 2) == 0) ? 8'($urandom) : 8'($urandom_range(0, 8));
			lane = $urandom_range(0, 9);
			if (lane < 3)
				req.rect_width = 16'($urandom);
			else if (lane < 8)
				req.rect_width = 16'($urandom_range(0, cols_used + 2));
			else
				req.rect_width = 16'($urandom_range(0, 3));
			lane = $urandom_range(0, 9);
			if (lane < 3)
				req.rect_height = 16'($urandom);
			else if (lane < 8)
				req.rect_height = 16'($urandom_range(0, rows_used + 2));
			else
				req.rect_height = 16'($urandom_range(0, 3));
		end else begin
			req.radius      = 8'($urandom_range(0, 6));
			req.rect_width  = 16'($urandom_range(0, 8));
			req.rect_height = 16'($urandom_range(0, 8));
		end

		req.material_value   = $urandom_range(0, 1) ? 8'($urandom_range(0, 3)) : 8'($urandom);
		req.background_value = 8'($urandom);
		return req;
	endfunction

	// One grid setting followed by random commands; idle_pct is the chance of a rest
	// with start low after each command, and pause_mid drains halfway through.
	task automatic run_phase(int w, int h, int n, int idle_pct, bit pause_mid);
		int i;
		set_grid(w, h);
		for (i = 0; i < n; i++) begin
			issue(random_item());
			if (pause_mid && i == n / 2)
				drain();
			else if ($urandom_range(0, 99) < idle_pct)
				rest($urandom_range(1, 4));
		end
	endtask

	initial begin
		int k;
		int w;
		int h;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed commands on the reset grid (256 x 256). The first one waits out
		// the clear pass, so it also shows cell (0,0) comes up zero.
		issue(make_cmd(CMD_READ, 0, 0, 0, 0, 0, 0, 0));
		issue(make_cmd(CMD_WRITE_CELL, 0, 0, 0, 0, 0, 8'hFF, 8'hFF));
		issue(make_cmd(CMD_READ, 0, 0, 0, 0, 0, 0, 0));
		issue(make_cmd(CMD_WRITE_CELL, 255, 255, 0, 0, 0, 8'h81, 8'h7E));
		issue(make_cmd(CMD_READ, 255, 255, 0, 0, 0, 0, 0));
		// off-grid reads, just past the high-x edge and the low-y edge, and at a far corner of the range
		issue(make_cmd(CMD_READ, 256, 0, 0, 0, 0, 0, 0));
		issue(make_cmd(CMD_READ, 0, -1, 0, 0, 0, 0, 0));
		issue(make_cmd(CMD_READ, -32768, 32767, 0, 0, 0, 0, 0));
		// off-grid writes must leave the store alone; then one cell's two fields and a read-back
		issue(make_cmd(CMD_WRITE_CELL, 32767, -32768, 0, 0, 0, 8'hFF, 8'hFF));
		issue(make_cmd(CMD_WRITE_MAT, 256, 3, 0, 0, 0, 8'h12, 8'h34));
		issue(make_cmd(CMD_WRITE_MAT, 3, 3, 0, 0, 0, 8'hAA, 8'h00));
		issue(make_cmd(CMD_WRITE_BG, 3, 3, 0, 0, 0, 8'h00, 8'h55));
		issue(make_cmd(CMD_READ, 3, 3, 0, 0, 0, 0, 0));
		// digs: a single cell, clipped at the corner, center off grid, box off grid
		issue(make_cmd(CMD_DIG_CIRCLE, 3, 3, 0, 0, 0, 8'h00, 0));
		issue(make_cmd(CMD_DIG_CIRCLE, 0, 0, 3, 0, 0, 8'h07, 0));
		issue(make_cmd(CMD_DIG_CIRCLE, -3, 10, 5, 0, 0, 8'h02, 0));
		issue(make_cmd(CMD_DIG_CIRCLE, -32768, -32768, 255, 0, 0, 8'h01, 0));
		// zero-size rectangles dig nothing; then one clipped at the origin, one past the far corner
		issue(make_cmd(CMD_DIG_RECT, 5, 5, 0, 0, 4, 8'h03, 0));
		issue(make_cmd(CMD_DIG_RECT, 5, 5, 0, 4, 0, 8'h03, 0));
		issue(make_cmd(CMD_DIG_RECT, -2, -2, 0, 5, 5, 8'h09, 0));
		issue(make_cmd(CMD_DIG_RECT, 254, 254, 0, 65535, 65535, 8'h01, 0));
		// unused codes only report in_bounds
		issue(make_cmd(CMD_SPARE_6, 1, 1, 0, 0, 0, 8'hFF, 8'hFF));
		issue(make_cmd(CMD_SPARE_7, 300, 1, 0, 0, 0, 8'hFF, 8'hFF));
		// the two full-size digs: widest circle, then the whole grid as a rectangle
		issue(make_cmd(CMD_DIG_CIRCLE, 128, 128, 255, 0, 0, 8'h33, 0));
		issue(make_cmd(CMD_DIG_RECT, 0, 0, 0, 65535, 65535, 8'h44, 0));
		issue(make_cmd(CMD_READ, 128, 128, 0, 0, 0, 0, 0));

		// Random part across grid sizes. Zero gives an empty grid, 511 and 300
		// saturate to the maximum; cells written earlier keep their address, so
		// small grids later read back what the large ones left behind.
		run_phase(0, 0, 40, 25, 1'b0);
		run_phase(1, 1, 120, 25, 1'b0);
		run_phase(511, 511, 150, 20, 1'b1);
		run_phase(1, 256, 120, 0, 1'b0);
		run_phase(256, 1, 120, 40, 1'b0);
		for (k = 0; k < 5; k++) begin
			w = $urandom_range(1, 32);
			h = $urandom_range(1, 32);
			run_phase(w, h, 120, 25 * (k % 3), 1'b0);
		end
		run_phase(300, 7, 60, 25, 1'b0);
		run_phase(256, 256, 150, 25, 1'b0);
		// closing stretch at full rate, no gaps
		run_phase($urandom_range(2, 24), $urandom_range(2, 24), 150, 0, 1'b0);
		drain();

		$display("Summary: %0d commands (%0d reads, %0d writes, %0d digs, %0d unused codes)",
			n_reads + n_writes + n_digs + n_spare, n_reads, n_writes, n_digs, n_spare);
		$display("Summary: %0d grid sizes, %0d results compared, %0d mismatches",
			n_grids, checked, fail_count);
		if (fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
